[sv/hilp_pkg.sv]
// Shared constants, types and state codes for the linear-probing hash insert block.
package hilp_pkg;

    // Field widths fixed by the interface.
    localparam int NAME_W  = 64;
    localparam int SLOT_W  = 4;
    localparam int MOD_W   = 4;
    localparam int BYTE_W  = 8;
    localparam int MAX_CHARS = NAME_W / BYTE_W;

    // Byte sum of up to eight unsigned bytes fits in eleven bits.
    localparam int SUM_W   = 11;

    // Probe lanes and the width of the probe position counter.
    localparam int LANES   = 4;
    localparam int POS_W   = SLOT_W + 1;

    // Defaults for the top-level parameters.
    localparam int SLOTS_DEF      = 16;
    localparam int NAME_CHARS_DEF = 8;

    // Reset value of the modulus register.
    localparam logic [MOD_W-1:0] MOD_RESET = 4'd15;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_MOD,
        ST_PROBE
    } t_state;

    // Status returned by the modulo unit.
    typedef struct packed {
        logic             done;
        logic [MOD_W-1:0] rem;
    } t_mod_res;

    // What one probe lane found.
    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } t_lane_res;

endpackage

[sv/hash_insert_linear_probe.sv]
// Top level of the linear-probing hash insert block with parallel probe lanes.
// A request is taken in the idle state, its byte sum is formed, the bit-serial modulo
// unit gives the home slot, and then probe steps of four lanes search for a free slot.
// One request at a time: the next is taken only after the result is stored in the
// output register, where a finished result waits until it is taken.
// Reset clears the occupancy bits and sets the modulus to 15; stored names stay undefined.
module hash_insert_linear_probe #(
    parameter int SLOTS      = hilp_pkg::SLOTS_DEF,
    parameter int NAME_CHARS = hilp_pkg::NAME_CHARS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [hilp_pkg::NAME_W-1:0] i_name_bytes,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [hilp_pkg::SLOT_W-1:0] o_slot_index,
    output logic                        o_table_full,
    input  logic                        i_cfg_we,
    input  logic [hilp_pkg::MOD_W-1:0]  i_cfg_data
);
    import hilp_pkg::*;

    // Only slots that a 4-bit modulus can reach are ever occupied.
    localparam int USE   = (SLOTS < (1 << SLOT_W)) ? SLOTS : (1 << SLOT_W);
    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_USE = SLOT_W'(USE - 1);

    t_state            r_state;
    t_state            n_state;
    logic [MOD_W-1:0]  r_modulus;
    logic [NAME_W-1:0] r_name;
    logic [SLOT_W-1:0] r_start;
    logic [POS_W-1:0]  r_pos;
    logic [USE-1:0]    r_used;
    logic              r_out_valid;
    logic [SLOT_W-1:0] r_out_slot;
    logic              r_out_full;
    logic [NAME_W-1:0] r_names [SLOTS];

    logic [NAME_W-1:0] w_masked;
    logic [SUM_W-1:0]  w_sum;
    logic [SLOT_W-1:0] w_limit;
    logic [POS_W-1:0]  w_span;
    logic [SLOT_W-1:0] w_home;
    logic [(1 << SLOT_W)-1:0] w_used;
    t_mod_res          w_mod;
    t_lane_res         w_lane [LANES];
    logic              w_hit;
    logic [SLOT_W-1:0] w_slot;
    logic              w_last;
    logic              w_finish;
    logic              w_out_free;
    logic              w_accept;
    logic              w_mod_start;
    logic              w_store;
    logic              w_step;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MOD_RESET;
        end else if (i_cfg_we) begin
            r_modulus <= i_cfg_data;
        end
    end

    // Keep only the configured number of name bytes.
    always_comb begin
        for (int i = 0; i < MAX_CHARS; i++) begin
            w_masked[i*BYTE_W +: BYTE_W] = (i < NAME_CHARS) ? i_name_bytes[i*BYTE_W +: BYTE_W]
                                                            : '0;
        end
    end

    // Unsigned byte sum of the captured name.
    always_comb begin
        w_sum = '0;
        for (int i = 0; i < NAME_CHARS; i++) begin
            w_sum = w_sum + SUM_W'(r_name[i*BYTE_W +: BYTE_W]);
        end
    end

    hilp_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (w_sum),
        .i_divisor  (r_modulus),
        .o_res      (w_mod)
    );

    // Last usable slot, probe span and home slot.
    always_comb begin
        w_limit = (r_modulus > LAST_USE) ? LAST_USE : r_modulus;
        w_span  = {1'b0, w_limit} + 1'b1;
        w_home  = (r_modulus == '0) ? '0 : w_mod.rem;
        w_used  = (1 << SLOT_W)'(r_used);
    end

    // Probe lanes, each one position further along the probe order.
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        hilp_lane u_lane (
            .i_pos   (r_pos + POS_W'(g)),
            .i_start (r_start),
            .i_span  (w_span),
            .i_used  (w_used),
            .o_res   (w_lane[g])
        );
    end

    // Merge: the lowest lane with a free slot wins.
    always_comb begin
        w_hit  = 1'b0;
        w_slot = '0;
        for (int i = LANES - 1; i >= 0; i--) begin
            if (w_lane[i].hit) begin
                w_hit  = 1'b1;
                w_slot = w_lane[i].slot;
            end
        end
        w_last   = ({1'b0, r_pos} + (POS_W + 1)'(LANES)) >= {1'b0, w_span};
        w_finish = w_hit || w_last;
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_SUM;
            end
            ST_SUM: begin
                n_state = ST_MOD;
            end
            ST_MOD: begin
                if (w_mod.done) n_state = ST_PROBE;
            end
            ST_PROBE: begin
                if (w_finish && w_out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control outputs of the state machine.
    always_comb begin
        o_in_ready  = 1'b0;
        w_mod_start = 1'b0;
        w_store     = 1'b0;
        w_step      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            ST_SUM: begin
                w_mod_start = 1'b1;
            end
            ST_MOD: begin
            end
            ST_PROBE: begin
                w_store = w_finish && w_out_free;
                w_step  = !w_finish;
            end
            default: begin
            end
        endcase
    end

    assign w_accept = i_in_valid && o_in_ready;

    // State register and occupancy bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_used  <= '0;
        end else begin
            r_state <= n_state;
            if (w_store && w_hit) begin
                for (int j = 0; j < USE; j++) begin
                    if (w_slot == SLOT_W'(j)) r_used[j] <= (r_name != '0);
                end
            end
        end
    end

    // Request capture and probe bookkeeping.
    always_ff @(posedge i_clk) begin
        if (w_accept) r_name <= w_masked;
        if (r_state == ST_MOD && w_mod.done) begin
            r_start <= (w_home <= w_limit) ? w_home : '0;
            r_pos   <= '0;
        end else if (w_step) begin
            r_pos <= r_pos + POS_W'(LANES);
        end
    end

    // Stored names.
    always_ff @(posedge i_clk) begin
        if (w_store && w_hit) r_names[AW'(w_slot)] <= r_name;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_store) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_out_slot <= w_hit ? w_slot : '0;
            r_out_full <= !w_hit;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_slot_index = r_out_slot;
    assign o_table_full = r_out_full;

endmodule

[sv/hilp_mod.sv]
// Iterative modulo unit: restoring division, one dividend bit per cycle.
module hilp_mod (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [hilp_pkg::SUM_W-1:0] i_dividend,
    input  logic [hilp_pkg::MOD_W-1:0] i_divisor,
    output hilp_pkg::t_mod_res         o_res
);
    import hilp_pkg::*;

    localparam int CNT_W = $clog2(SUM_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SUM_W - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [SUM_W-1:0] r_div;
    logic [MOD_W-1:0] r_rem;

    logic [MOD_W:0]   w_trial;
    logic [MOD_W-1:0] w_rem_next;

    // One restoring step: shift in the next bit and subtract when it fits.
    always_comb begin
        w_trial = {r_rem, r_div[SUM_W-1]};
        if (w_trial >= {1'b0, i_divisor}) begin
            w_rem_next = MOD_W'(w_trial - {1'b0, i_divisor});
        end else begin
            w_rem_next = w_trial[MOD_W-1:0];
        end
    end

    // Control: count the steps and flag the last one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend shift register and partial remainder.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_div <= {r_div[SUM_W-2:0], 1'b0};
            r_rem <= w_rem_next;
        end
    end

    assign o_res.done = r_done;
    assign o_res.rem  = r_rem;

endmodule

[sv/hilp_lane.sv]
// One probe lane: maps a probe position to a slot and checks whether it is free.
module hilp_lane (
    input  logic [hilp_pkg::POS_W-1:0]    i_pos,
    input  logic [hilp_pkg::SLOT_W-1:0]   i_start,
    input  logic [hilp_pkg::POS_W-1:0]    i_span,
    input  logic [(1 << hilp_pkg::SLOT_W)-1:0] i_used,
    output hilp_pkg::t_lane_res           o_res
);
    import hilp_pkg::*;

    logic [POS_W:0] w_raw;
    logic [POS_W:0] w_wrap;
    logic           w_active;

    // Wrap the start-relative position once around the usable span.
    always_comb begin
        w_active = (i_pos < i_span);
        w_raw    = {1'b0, {1'b0, i_start} + i_pos};
        if (w_raw >= {1'b0, i_span}) begin
            w_wrap = w_raw - {1'b0, i_span};
        end else begin
            w_wrap = w_raw;
        end
        o_res.slot = w_wrap[SLOT_W-1:0];
        o_res.hit  = w_active && !i_used[w_wrap[SLOT_W-1:0]];
    end

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the linear-probing hash insert block.
`timescale 1ns / 100ps

module tb_top;

    localparam int SW = hilp_pkg::SLOT_W;
    localparam int NW = hilp_pkg::NAME_W;
    localparam int MW = hilp_pkg::MOD_W;
    localparam int TABLE_SLOTS = 16;
    localparam int SETTLE_CYCLES = 24;
    localparam int RAND_PHASES = 10;
    localparam int PHASE_ITEMS = 123;
    localparam int PLAN_LEN = 22;

    // One insert outcome as the block reports it.
    typedef struct packed {
        logic [SW-1:0] slot;
        logic          full;
    } t_insert_res;

    typedef enum logic {
        ROW_CFG,
        ROW_NAME
    } t_row_kind;

    // One row of the directed plan; lit marks a typed-in expectation.
    typedef struct packed {
        t_row_kind     kind;
        logic [MW-1:0] modulus;
        logic [NW-1:0] name;
        logic          lit;
        logic [SW-1:0] slot;
        logic          full;
    } t_row;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_in_valid = 1'b0;
    logic          o_in_ready;
    logic [NW-1:0] i_name_bytes = '0;
    logic          o_out_valid;
    logic          i_out_ready = 1'b0;
    logic [SW-1:0] o_slot_index;
    logic          o_table_full;
    logic          i_cfg_we = 1'b0;
    logic [MW-1:0] i_cfg_data = '0;

    // Predictor state: occupancy, stored names and the modulus register.
    bit            model_used [TABLE_SLOTS];
    logic [NW-1:0] model_names [TABLE_SLOTS];
    logic [MW-1:0] model_mod = hilp_pkg::MOD_RESET;

    t_insert_res pending_inserts [$];
    int          err_count = 0;
    bit          idle_on = 1'b1;

    t_row plan [PLAN_LEN] = '{
        '{ROW_NAME, 4'd0,  64'h0,                  1'b1, 4'd0, 1'b0},
        '{ROW_NAME, 4'd0,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 4'd0, 1'b0},
        '{ROW_NAME, 4'd0,  64'h41,                 1'b0, 4'd0, 1'b0},
        '{ROW_CFG,  4'd0,  64'h0,                  1'b0, 4'd0, 1'b0},
        '{ROW_NAME, 4'd0,  64'h01,                 1'b1, 4'd0, 1'b1},
        '{ROW_NAME, 4'd0,  64'h0,                  1'b1, 4'd0, 1'b1},
        '{ROW_CFG,  4'd1,  64'h0,                  1'b0, 4'd0, 1'b0},
        '{ROW_NAME, 4'd0,  64'h0202,               1'b0, 4'd0, 1'b0},
        '{ROW_NAME, 4'd0,  64'h03,                 1'b1, 4'd0, 1'b1},
        '{ROW_CFG,  4'd15, 64'h0,                  1'b0, 4'd0, 1'b0},
        '{ROW_NAME, 4'd0,  64'h0E,                 1'b0, 4'd0, 1'b0},
        '{ROW_NAME, 4'd0,  64'h0E,                 1'b0, 4'd0, 1'b0},
        '{ROW_NAME, 4'd0,  64'h0E,                 1'b0, 4'd0, 1'b0},
        '{ROW_CFG,  4'd4,  64'h0,                  1'b0, 4'd0, 1'b0},
        '{ROW_NAME, 4'd0,  64'h0100,               1'b0, 4'd0, 1'b0},
        '{ROW_NAME, 4'd0,  64'h8000_0000_0000_0000, 1'b0, 4'd0, 1'b0},
        '{ROW_NAME, 4'd0,  64'h01,                 1'b1, 4'd0, 1'b1},
        '{ROW_NAME, 4'd0,  64'h0,                  1'b1, 4'd0, 1'b1},
        '{ROW_CFG,  4'd7,  64'h0,                  1'b0, 4'd0, 1'b0},
        '{ROW_NAME, 4'd0,  64'h0707,               1'b0, 4'd0, 1'b0},
        '{ROW_NAME, 4'd0,  64'h0,                  1'b0, 4'd0, 1'b0},
        '{ROW_NAME, 4'd0,  64'h0,                  1'b0, 4'd0, 1'b0}
    };

    hash_insert_linear_probe dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_name_bytes (i_name_bytes),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_slot_index (o_slot_index),
        .o_table_full (o_table_full),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Hash the name, probe from the home slot with one wrap, and update occupancy.
    function automatic t_insert_res probe_insert(logic [NW-1:0] name);
        t_insert_res   r;
        logic [10:0]   sum;
        logic [MW-1:0] home;
        int            k;
        bit            found;
        sum = '0;
        for (k = 0; k < 8; k++) sum += name[8*k +: 8];
        home = (model_mod == 0) ? '0 : MW'(sum % model_mod);
        found = 1'b0;
        r = '0;
        for (k = home; k <= model_mod && !found; k++) begin
            if (!model_used[k]) begin
                found = 1'b1;
                r.slot = SW'(k);
            end
        end
        for (k = 0; k <= model_mod && !found; k++) begin
            if (!model_used[k]) begin
                found = 1'b1;
                r.slot = SW'(k);
            end
        end
        if (found) begin
            model_names[r.slot] = name;
            model_used[r.slot] = (name != 0);
        end else begin
            r.full = 1'b1;
        end
        return r;
    endfunction

    // True when every slot the current modulus allows is occupied.
    function automatic bit usable_slots_taken();
        int k;
        for (k = 0; k <= model_mod; k++) if (!model_used[k]) return 1'b0;
        return 1'b1;
    endfunction

    // Random name: mostly empty names while slots remain, real names once they run out.
    function automatic logic [NW-1:0] random_name();
        logic [NW-1:0] name;
        int            len;
        int            k;
        name = '0;
        if (!usable_slots_taken() && $urandom_range(0, 99) >= 6) return name;
        case ($urandom_range(0, 2))
            0: begin
                name = {$urandom, $urandom};
            end
            1: begin
                len = $urandom_range(1, 8);
                for (k = 0; k < len; k++) name[8*k +: 8] = 8'($urandom_range(1, 255));
            end
            default: begin
                name[8*$urandom_range(0, 7) +: 8] = 8'($urandom_range(1, 255));
            end
        endcase
        return name;
    endfunction

    // Offer one request, after a random gap while idle_on is set, and record its expected outcome on accept.
    task automatic send_name(logic [NW-1:0] name, logic lit, logic [SW-1:0] lit_slot,
                             logic lit_full);
        int          gap;
        t_insert_res res;
        gap = idle_on ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_name_bytes <= name;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        res = probe_insert(name);
        if (lit) begin
            res.slot = lit_slot;
            res.full = lit_full;
        end
        pending_inserts.push_back(res);
    endtask

    // Stop offering, wait for every outstanding result, then let the block go quiet.
    task automatic drain_block();
        i_in_valid <= 1'b0;
        while (pending_inserts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the modulus register while the block is idle.
    task automatic write_modulus(logic [MW-1:0] value);
        drain_block();
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        model_mod = value;
    endtask

    // Request side: reset, directed plan, then random phases.
    initial begin
        int            r;
        int            p;
        int            n;
        logic [MW-1:0] m;
        for (r = 0; r < TABLE_SLOTS; r++) model_used[r] = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (r = 0; r < PLAN_LEN; r++) begin
            if (plan[r].kind == ROW_CFG) begin
                write_modulus(plan[r].modulus);
            end else begin
                send_name(plan[r].name, plan[r].lit, plan[r].slot, plan[r].full);
            end
        end

        for (p = 0; p < RAND_PHASES; p++) begin
            if (p == 0) m = '0;
            else if (p == RAND_PHASES - 1) m = 4'd15;
            else m = MW'($urandom_range(0, 15));
            write_modulus(m);
            idle_on = (p % 3 != 1);
            for (n = 0; n < PHASE_ITEMS; n++) send_name(random_name(), 1'b0, '0, 1'b0);
        end

        idle_on = 1'b1;
        drain_block();
        if (err_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Result side: random stalls while idle_on is set, then compare each accepted result with the oldest one due.
    initial begin
        int          stall;
        t_insert_res want;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = idle_on ? $urandom_range(0, 19) : 0;
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            if (pending_inserts.size() == 0) begin
                err_count++;
                $display("%0t: unexpected result slot_index %0d table_full %0b",
                         $time, o_slot_index, o_table_full);
            end else begin
                want = pending_inserts.pop_front();
                if (o_slot_index !== want.slot) begin
                    err_count++;
                    $display("%0t: slot_index expected %0d actual %0d",
                             $time, want.slot, o_slot_index);
                end
                if (o_table_full !== want.full) begin
                    err_count++;
                    $display("%0t: table_full expected %0b actual %0b",
                             $time, want.full, o_table_full);
                end
            end
        end
    end

endmodule
